// File: rtl/core/qbst_pkg.sv
// Shared types, codes and constants of the quote book staleness table.
package qbst_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);

  // operation codes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_REJ_ORDER   = 2'd1;
  localparam logic [1:0] ST_REJ_CROSSED = 2'd2;
  localparam logic [1:0] ST_ANSWER      = 2'd3;

  // quote condition codes
  localparam logic [2:0] COND_NORMAL  = 3'd0;
  localparam logic [2:0] COND_LOCKED  = 3'd1;
  localparam logic [2:0] COND_CROSSED = 3'd2;
  localparam logic [2:0] COND_STALE   = 3'd3;
  localparam logic [2:0] COND_ABSENT  = 3'd4;

  // venue trading states
  localparam logic [1:0] VENUE_TRADING = 2'd0;
  localparam logic [1:0] VENUE_CLOSED  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TIER   = 2'd0;
  localparam logic [1:0] CFG_BUDGET = 2'd1;
  localparam logic [1:0] CFG_REJECT = 2'd2;

  // sampling tiers
  localparam logic [1:0] TIER_SECOND     = 2'd1;
  localparam logic [1:0] TIER_CONTINUOUS = 2'd2;

  // default staleness budgets in ns
  localparam logic [39:0] BUDGET_MINUTE     = 40'd60_000_000_000;
  localparam logic [39:0] BUDGET_SECOND     = 40'd2_000_000_000;
  localparam logic [39:0] BUDGET_CONTINUOUS = 40'd5_000_000_000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  instrument;
    logic [31:0] bid_price;
    logic [31:0] ask_price;
    logic [31:0] bid_quantity;
    logic [31:0] ask_quantity;
    logic [62:0] timestamp;
    logic [1:0]  venue_state;
  } item_t;

  typedef struct packed {
    logic [31:0] bid;
    logic [31:0] ask;
    logic [31:0] bid_quantity;
    logic [31:0] ask_quantity;
    logic [62:0] received;
  } quote_t;

  typedef struct packed {
    logic       exists;
    logic       present;
    logic [1:0] venue;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         condition;
    logic [1:0]         held_state;
    logic               quote_present;
    logic [31:0]        held_bid;
    logic [31:0]        held_ask;
    logic [31:0]        held_bid_quantity;
    logic [31:0]        held_ask_quantity;
    logic signed [63:0] quote_age;
    logic               executable;
  } result_t;

  typedef struct packed {
    logic set_exists;
    logic set_present;
    logic quote_we;
    logic state_we;
    logic clear_all;
  } action_t;

endpackage

// File: rtl/core/qbst_if.sv
// Valid/ready channel interfaces for items in and results out.
interface qbst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  instrument;
  logic [31:0] bid_price;
  logic [31:0] ask_price;
  logic [31:0] bid_quantity;
  logic [31:0] ask_quantity;
  logic [62:0] timestamp;
  logic [1:0]  venue_state;

  modport source (
    output valid, opcode, instrument, bid_price, ask_price, bid_quantity,
           ask_quantity, timestamp, venue_state,
    input  ready
  );
  modport sink (
    input  valid, opcode, instrument, bid_price, ask_price, bid_quantity,
           ask_quantity, timestamp, venue_state,
    output ready
  );
endinterface

interface qbst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         condition;
  logic [1:0]         held_state;
  logic               quote_present;
  logic [31:0]        held_bid;
  logic [31:0]        held_ask;
  logic [31:0]        held_bid_quantity;
  logic [31:0]        held_ask_quantity;
  logic signed [63:0] quote_age;
  logic               executable;

  modport source (
    output valid, status, condition, held_state, quote_present, held_bid, held_ask,
           held_bid_quantity, held_ask_quantity, quote_age, executable,
    input  ready
  );
  modport sink (
    input  valid, status, condition, held_state, quote_present, held_bid, held_ask,
           held_bid_quantity, held_ask_quantity, quote_age, executable,
    output ready
  );
endinterface

// File: rtl/core/quote_book_staleness_table.sv
// Top level: quote and entry memories, config registers, clearing pass and output register.
// Items and memory reads are registered on accept; the result is registered in the
// execute state and held in the output register. Items are taken only when idle with the
// output register free or read, so none enters before the last is written back; a clear
// holds the input off while its pass walks every entry. Reset: configuration returns to
// defaults, then a pass (input held off) zeroes entry flags and trading state, not quotes.
module quote_book_staleness_table (
  input  logic               clk,
  input  logic               rst_n,
  qbst_in_if.sink            in_item,
  qbst_out_if.source         out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_wdata
);
  import qbst_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        tier_r;
  logic [39:0]       budget_r;
  logic              refuse_crossed_r;
  item_t             item_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  in_idx;
  logic              in_acc;
  logic [IDX_W-1:0]  clr_idx_r;
  logic              clr_full_r;
  logic              clr_last;

  quote_t            quote_mem [ENTRIES];
  entry_t            entry_mem [ENTRIES];
  quote_t            quote_rd_r;
  entry_t            entry_rd_r;
  entry_t            entry_wr;

  result_t           res;
  action_t           act;
  result_t           out_r;
  logic              out_valid_r;
  quote_t            quote_wr;

  assign in_item.ready = (state_r == ST_IDLE) && (!out_valid_r || out_item.ready);
  assign in_acc        = in_item.valid && in_item.ready;
  assign in_idx        = in_item.instrument[IDX_W-1:0];
  assign clr_last      = (clr_idx_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = act.clear_all ? ST_CLEAR : ST_IDLE;
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tier_r           <= 2'd0;
      budget_r         <= 40'd0;
      refuse_crossed_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIER:   tier_r           <= cfg_wdata[1:0];
        CFG_BUDGET: budget_r         <= cfg_wdata;
        CFG_REJECT: refuse_crossed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // capture the item being worked on
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.opcode       <= in_item.opcode;
      item_r.instrument   <= in_item.instrument;
      item_r.bid_price    <= in_item.bid_price;
      item_r.ask_price    <= in_item.ask_price;
      item_r.bid_quantity <= in_item.bid_quantity;
      item_r.ask_quantity <= in_item.ask_quantity;
      item_r.timestamp    <= in_item.timestamp;
      item_r.venue_state  <= in_item.venue_state;
      idx_r               <= in_idx;
    end
  end

  assign quote_wr.bid          = item_r.bid_price;
  assign quote_wr.ask          = item_r.ask_price;
  assign quote_wr.bid_quantity = item_r.bid_quantity;
  assign quote_wr.ask_quantity = item_r.ask_quantity;
  assign quote_wr.received     = item_r.timestamp;

  always_comb begin
    entry_wr = entry_rd_r;
    if (act.set_exists)  entry_wr.exists  = 1'b1;
    if (act.set_present) entry_wr.present = 1'b1;
    if (act.state_we)    entry_wr.venue   = item_r.venue_state;
  end

  // quote memory: read on accept, write back in the execute cycle
  always_ff @(posedge clk) begin
    if (in_acc) quote_rd_r <= quote_mem[in_idx];
    if ((state_r == ST_EXEC) && act.quote_we) quote_mem[idx_r] <= quote_wr;
  end

  // entry memory: read on accept, write back in the execute cycle, wipe during the pass;
  // the reset pass also zeroes the trading state so an unset entry reads as trading
  always_ff @(posedge clk) begin
    if (in_acc) entry_rd_r <= entry_mem[in_idx];
    if (state_r == ST_EXEC) entry_mem[idx_r] <= entry_wr;
    if (state_r == ST_CLEAR) begin
      if (clr_full_r) begin
        entry_mem[clr_idx_r] <= '0;
      end else begin
        entry_mem[clr_idx_r].exists  <= 1'b0;
        entry_mem[clr_idx_r].present <= 1'b0;
      end
    end
  end

  qbst_exec u_exec (
    .item           (item_r),
    .held           (quote_rd_r),
    .exists         (entry_rd_r.exists),
    .present        (entry_rd_r.present),
    .venue          (entry_rd_r.venue),
    .tier           (tier_r),
    .budget         (budget_r),
    .refuse_crossed (refuse_crossed_r),
    .res            (res),
    .act            (act)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clr_full_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end else if ((state_r == ST_EXEC) && act.clear_all) begin
        clr_idx_r  <= '0;
        clr_full_r <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) out_r <= res;
  end

  assign out_item.valid             = out_valid_r;
  assign out_item.status            = out_r.status;
  assign out_item.condition         = out_r.condition;
  assign out_item.held_state        = out_r.held_state;
  assign out_item.quote_present     = out_r.quote_present;
  assign out_item.held_bid          = out_r.held_bid;
  assign out_item.held_ask          = out_r.held_ask;
  assign out_item.held_bid_quantity = out_r.held_bid_quantity;
  assign out_item.held_ask_quantity = out_r.held_ask_quantity;
  assign out_item.quote_age         = out_r.quote_age;
  assign out_item.executable        = out_r.executable;

endmodule

// File: rtl/core/qbst_exec.sv
// Operation decode, staleness classification and write-back decisions.
module qbst_exec (
  input  qbst_pkg::item_t   item,
  input  qbst_pkg::quote_t  held,
  input  logic              exists,
  input  logic              present,
  input  logic [1:0]        venue,
  input  logic [1:0]        tier,
  input  logic [39:0]       budget,
  input  logic              refuse_crossed,
  output qbst_pkg::result_t res,
  output qbst_pkg::action_t act
);
  import qbst_pkg::*;

  logic        older;
  logic [63:0] age;
  logic [39:0] budget_eff;
  logic        stale;
  logic [2:0]  cond;

  assign older = item.timestamp < held.received;
  assign age   = {1'b0, item.timestamp} - {1'b0, held.received};

  always_comb begin
    priority if (budget != 40'd0) begin
      budget_eff = budget;
    end else if (tier == TIER_SECOND) begin
      budget_eff = BUDGET_SECOND;
    end else if (tier == TIER_CONTINUOUS) begin
      budget_eff = BUDGET_CONTINUOUS;
    end else begin
      budget_eff = BUDGET_MINUTE;
    end
  end

  // a future quote wraps to a huge age, but flag it explicitly anyway
  assign stale = older || (age > {24'd0, budget_eff});

  always_comb begin
    priority if (stale) begin
      cond = COND_STALE;
    end else if (held.ask < held.bid) begin
      cond = COND_CROSSED;
    end else if (held.ask == held.bid) begin
      cond = COND_LOCKED;
    end else begin
      cond = COND_NORMAL;
    end
  end

  always_comb begin
    res = '0;
    act = '0;
    unique case (item.opcode)
      OP_UPDATE: begin
        act.set_exists = 1'b1;
        priority if (present && older) begin
          res.status = ST_REJ_ORDER;
        end else if ((item.ask_price < item.bid_price) && refuse_crossed) begin
          res.status = ST_REJ_CROSSED;
        end else begin
          res.status      = ST_DONE;
          act.quote_we    = 1'b1;
          act.set_present = 1'b1;
        end
      end
      OP_SET: begin
        act.set_exists = 1'b1;
        act.state_we   = 1'b1;
        res.status     = ST_DONE;
      end
      OP_QUERY: begin
        res.status = ST_ANSWER;
        if (!present) begin
          res.condition  = COND_ABSENT;
          res.held_state = exists ? venue : VENUE_CLOSED;
        end else begin
          res.condition         = cond;
          res.held_state        = venue;
          res.quote_present     = 1'b1;
          res.held_bid          = held.bid;
          res.held_ask          = held.ask;
          res.held_bid_quantity = held.bid_quantity;
          res.held_ask_quantity = held.ask_quantity;
          res.quote_age         = age;
          res.executable        = (venue == VENUE_TRADING) &&
                                  ((cond == COND_NORMAL) || (cond == COND_LOCKED));
        end
      end
      OP_CLEAR: begin
        act.clear_all = 1'b1;
        res.status    = ST_DONE;
      end
      default: begin
        res = '0;
        act = '0;
      end
    endcase
  end

endmodule

// File: tb/tb_quote_book_staleness_table.sv
// Testbench for the quote book staleness table: directed and random items checked against a predictor.
module tb_quote_book_staleness_table;
  import qbst_pkg::*;

  localparam logic [1:0] VENUE_HALTED  = 2'd1;
  localparam logic [1:0] VENUE_AUCTION = 2'd3;
  localparam logic [1:0] TIER_MINUTE   = 2'd0;
  localparam logic [1:0] TIER_UNUSED   = 2'd3;
  localparam int         RUN_LIMIT     = 4_000_000;
  localparam int         DRAIN_LIMIT   = 5_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [39:0] cfg_wdata;

  qbst_in_if  in_ch();
  qbst_out_if out_ch();

  quote_book_staleness_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted book contents and register shadows
  bit          book_exists [ENTRIES];
  bit          book_present[ENTRIES];
  bit          state_known [ENTRIES];
  bit   [1:0]  book_state  [ENTRIES];
  bit   [31:0] book_bid    [ENTRIES];
  bit   [31:0] book_ask    [ENTRIES];
  bit   [31:0] book_bid_qty[ENTRIES];
  bit   [31:0] book_ask_qty[ENTRIES];
  bit   [62:0] book_recv   [ENTRIES];
  logic [1:0]  tier_reg;
  logic [39:0] budget_reg;
  logic        reject_reg;

  result_t awaited_results[$];
  bit      idle_on = 1'b1;
  int      out_stall;
  int      mismatches;
  int      items_sent;
  int      results_checked;
  int      settings_applied;
  int      refused_updates;
  int      answers_seen[5];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [39:0] active_budget();
    if (budget_reg != 40'd0) return budget_reg;
    case (tier_reg)
      TIER_SECOND:     return BUDGET_SECOND;
      TIER_CONTINUOUS: return BUDGET_CONTINUOUS;
      default:         return BUDGET_MINUTE;
    endcase
  endfunction

  function automatic result_t apply_to_book(item_t it);
    result_t     r;
    logic [7:0]  idx;
    logic [63:0] age;
    logic [2:0]  cond;
    r = '0;
    idx = it.instrument;
    case (it.opcode)
      OP_UPDATE: begin
        book_exists[idx] = 1'b1;
        if (book_present[idx] && it.timestamp < book_recv[idx]) begin
          r.status = ST_REJ_ORDER;
          refused_updates++;
        end else if (it.ask_price < it.bid_price && reject_reg) begin
          r.status = ST_REJ_CROSSED;
          refused_updates++;
        end else begin
          book_bid[idx]     = it.bid_price;
          book_ask[idx]     = it.ask_price;
          book_bid_qty[idx] = it.bid_quantity;
          book_ask_qty[idx] = it.ask_quantity;
          book_recv[idx]    = it.timestamp;
          book_present[idx] = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_SET: begin
        book_exists[idx] = 1'b1;
        book_state[idx]  = it.venue_state;
        state_known[idx] = 1'b1;
        r.status = ST_DONE;
      end
      OP_QUERY: begin
        r.status = ST_ANSWER;
        if (!book_present[idx]) begin
          r.condition  = COND_ABSENT;
          r.held_state = book_exists[idx] ? book_state[idx] : VENUE_CLOSED;
        end else begin
          age = {1'b0, it.timestamp} - {1'b0, book_recv[idx]};
          if (it.timestamp < book_recv[idx] || age > {24'd0, active_budget()})
            cond = COND_STALE;
          else if (book_ask[idx] < book_bid[idx])
            cond = COND_CROSSED;
          else if (book_ask[idx] == book_bid[idx])
            cond = COND_LOCKED;
          else
            cond = COND_NORMAL;
          r.condition         = cond;
          r.held_state        = book_state[idx];
          r.quote_present     = 1'b1;
          r.held_bid          = book_bid[idx];
          r.held_ask          = book_ask[idx];
          r.held_bid_quantity = book_bid_qty[idx];
          r.held_ask_quantity = book_ask_qty[idx];
          r.quote_age         = age;
          r.executable        = (book_state[idx] == VENUE_TRADING) &&
                                (cond == COND_NORMAL || cond == COND_LOCKED);
        end
        answers_seen[r.condition]++;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          book_exists[i]  = 1'b0;
          book_present[i] = 1'b0;
        end
        r.status = ST_DONE;
      end
    endcase
    return r;
  endfunction

  function automatic item_t book_item(logic [1:0] op, logic [7:0] inst, logic [31:0] bid,
                                      logic [31:0] ask, logic [31:0] bq, logic [31:0] aq,
                                      logic [62:0] ts, logic [1:0] vs);
    item_t it;
    it.opcode       = op;
    it.instrument   = inst;
    it.bid_price    = bid;
    it.ask_price    = ask;
    it.bid_quantity = bq;
    it.ask_quantity = aq;
    it.timestamp    = ts;
    it.venue_state  = vs;
    return it;
  endfunction

  // Mostly well-formed traffic on a handful of instruments, timed around the budget
  function automatic item_t next_random_item();
    item_t       it;
    logic [7:0]  inst;
    logic [63:0] off;
    logic [39:0] bud;
    int          pick;
    it = book_item(2'($urandom), 8'($urandom), $urandom, $urandom, $urandom, $urandom,
                   63'(rand64()), 2'($urandom));
    inst = ($urandom_range(0, 6) == 0) ? 8'($urandom)
         : {($urandom_range(0, 1) ? 5'h1F : 5'h00), 3'($urandom_range(0, 7))};
    it.instrument = inst;
    pick = $urandom_range(0, 199);
    if (pick < 2) begin
      it.opcode = OP_CLEAR;
    end else if (pick < 80) begin
      it.opcode = OP_UPDATE;
      case ($urandom_range(0, 9))
        0: it.timestamp = book_recv[inst] - 63'($urandom_range(1, 1000));
        1: ;
        default: it.timestamp = book_recv[inst] + 63'($urandom_range(0, 1_500_000_000));
      endcase
      if ($urandom_range(0, 9) != 0) begin
        it.bid_price = $urandom_range(1000, 2000);
        it.ask_price = it.bid_price + 32'($urandom_range(0, 8)) - 32'd3;
      end
    end else if (pick < 105 || (book_exists[inst] && !state_known[inst])) begin
      // never read a trading state that was not written
      it.opcode = OP_SET;
      if ($urandom_range(0, 1)) it.venue_state = VENUE_TRADING;
    end else begin
      it.opcode = OP_QUERY;
      bud = active_budget();
      case ($urandom_range(0, 7))
        0: off = 64'd0;
        1: off = {24'd0, bud};
        2: off = {24'd0, bud} + 64'd1;
        3, 4: off = rand64() % ({24'd0, bud} + 64'd1);
        5: off = -64'($urandom_range(1, 1000));
        6: off = 64'd0;
        default: off = rand64() % ({23'd0, bud, 1'b0} + 64'd2);
      endcase
      if (!(off == 64'd0 && $urandom_range(0, 3) == 0))
        it.timestamp = 63'({1'b0, book_recv[inst]} + off);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  task automatic send_item(input item_t it);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.opcode       = it.opcode;
    in_ch.instrument   = it.instrument;
    in_ch.bid_price    = it.bid_price;
    in_ch.ask_price    = it.ask_price;
    in_ch.bid_quantity = it.bid_quantity;
    in_ch.ask_quantity = it.ask_quantity;
    in_ch.timestamp    = it.timestamp;
    in_ch.venue_state  = it.venue_state;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_results.push_back(apply_to_book(it));
    items_sent++;
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and hold until every awaited result is back or the drain limit runs out, then let the pipe settle
  task automatic drain_results();
    int waited;
    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [39:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_TIER:   tier_reg   = data[1:0];
      CFG_BUDGET: budget_reg = data;
      CFG_REJECT: reject_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [1:0] tier_v, input logic [39:0] budget_v,
                           input logic reject_v, input int count);
    drain_results();
    cfg_write(CFG_TIER, {38'd0, tier_v});
    cfg_write(CFG_BUDGET, budget_v);
    cfg_write(CFG_REJECT, {39'd0, reject_v});
    settings_applied++;
    repeat (count) begin
      if (idle_on && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 9));
      send_item(next_random_item());
    end
  endtask

  task automatic test_directed_book_ops();
    send_item(book_item(OP_QUERY, 8'd5, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_SET, 8'd5, 0, 0, 0, 0, 63'd0, VENUE_HALTED));
    send_item(book_item(OP_QUERY, 8'd5, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_SET, 8'd0, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_UPDATE, 8'd0, 32'd0, '1, '1, 32'd0, 63'd0, VENUE_TRADING));
    // age exactly at the budget, then one past it
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'(BUDGET_MINUTE), VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'(BUDGET_MINUTE) + 63'd1,
                        VENUE_TRADING));
    send_item(book_item(OP_UPDATE, 8'd0, '1, '1, 32'd0, '1, 63'd1000, VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'd1000, VENUE_TRADING));
    send_item(book_item(OP_UPDATE, 8'd0, 32'd7, 32'd8, 32'd1, 32'd1, 63'd999,
                        VENUE_TRADING));
    send_item(book_item(OP_UPDATE, 8'd0, 32'd10, 32'd9, 32'd1, 32'd1, 63'd2000,
                        VENUE_TRADING));
    // quote from the future reads as stale
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'd500, VENUE_TRADING));
    send_item(book_item(OP_SET, 8'd0, 0, 0, 0, 0, 63'd0, VENUE_AUCTION));
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'd1000, VENUE_TRADING));
    send_item(book_item(OP_SET, 8'd255, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_UPDATE, 8'd255, 32'd1, 32'd2, '1, '1, '1, VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd255, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd255, 0, 0, 0, 0, '1, VENUE_TRADING));
    send_item(book_item(OP_SET, 8'd7, 0, 0, 0, 0, 63'd0, VENUE_HALTED));
    send_item(book_item(OP_CLEAR, 8'd0, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd0, 0, 0, 0, 0, 63'd1000, VENUE_TRADING));
    // a refused update still recreates the entry
    send_item(book_item(OP_UPDATE, 8'd7, 32'd5, 32'd4, 32'd1, 32'd1, 63'd0, VENUE_TRADING));
    send_item(book_item(OP_QUERY, 8'd7, 0, 0, 0, 0, 63'd0, VENUE_TRADING));
  endtask

  task automatic test_tier_defaults();
    run_phase(TIER_SECOND, 40'd0, 1'b1, 140);
    run_phase(TIER_CONTINUOUS, 40'd0, 1'b0, 140);
    run_phase(TIER_UNUSED, 40'd0, 1'b1, 140);
  endtask

  task automatic test_budget_extremes();
    run_phase(TIER_MINUTE, 40'd1, 1'b0, 140);
    run_phase(TIER_CONTINUOUS, '1, 1'b1, 140);
  endtask

  task automatic test_random_settings();
    run_phase(2'($urandom), 40'(rand64()), 1'($urandom), 140);
    idle_on = 1'b0;
    run_phase(TIER_MINUTE, 40'd0, 1'b1, 120);
  endtask

  // Result side: stall in random bursts while idle_on is set, else always ready
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ch.ready = 1'b1;
    end else if (out_stall > 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      out_stall = $urandom_range(1, 9) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", 64'd0, 64'd1);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("condition", 64'(want.condition), 64'(out_ch.condition));
        check_field("held_state", 64'(want.held_state), 64'(out_ch.held_state));
        check_field("quote_present", 64'(want.quote_present), 64'(out_ch.quote_present));
        check_field("held_bid", 64'(want.held_bid), 64'(out_ch.held_bid));
        check_field("held_ask", 64'(want.held_ask), 64'(out_ch.held_ask));
        check_field("held_bid_quantity", 64'(want.held_bid_quantity),
                    64'(out_ch.held_bid_quantity));
        check_field("held_ask_quantity", 64'(want.held_ask_quantity),
                    64'(out_ch.held_ask_quantity));
        check_field("quote_age", 64'(want.quote_age), 64'(out_ch.quote_age));
        check_field("executable", 64'(want.executable), 64'(out_ch.executable));
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TIER;
    cfg_wdata          = 40'd0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_UPDATE;
    in_ch.instrument   = 8'd0;
    in_ch.bid_price    = 32'd0;
    in_ch.ask_price    = 32'd0;
    in_ch.bid_quantity = 32'd0;
    in_ch.ask_quantity = 32'd0;
    in_ch.timestamp    = 63'd0;
    in_ch.venue_state  = VENUE_TRADING;
    out_ch.ready       = 1'b0;
    tier_reg           = TIER_MINUTE;
    budget_reg         = 40'd0;
    reject_reg         = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_book_ops();
    test_tier_defaults();
    test_budget_extremes();
    test_random_settings();

    drain_results();
    if (awaited_results.size() != 0)
      report_mismatch("results never returned", 64'(awaited_results.size()), 64'd0);
    $display("%0d items under %0d register settings, %0d results checked, %0d updates refused",
             items_sent, settings_applied + 1, results_checked, refused_updates);
    $display("query answers: normal %0d, locked %0d, crossed %0d, stale %0d, absent %0d",
             answers_seen[COND_NORMAL], answers_seen[COND_LOCKED], answers_seen[COND_CROSSED],
             answers_seen[COND_STALE], answers_seen[COND_ABSENT]);
    if (mismatches == 0) begin
      $display("quote_book_staleness_table test passed");
    end else begin
      $display("quote_book_staleness_table test failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("quote_book_staleness_table test failed");
    $finish;
  end

endmodule
